// File: rtl/sdcdp_pkg.sv
// Shared constants and controller/datapath interface types for the
// SD card clock divider planner. No dependencies.
package sdcdp_pkg;

  localparam int FREQ_W   = 30;
  localparam int WORD_W   = 32;
  localparam int PREDIV_W = 2;
  localparam int CNT_W    = $clog2(FREQ_W);

  localparam logic [FREQ_W-1:0]   OSC_FREQ   = FREQ_W'(24000000);
  localparam logic [FREQ_W-1:0]   BAND_SLOW  = FREQ_W'(400000);
  localparam logic [FREQ_W-1:0]   BAND_SD    = FREQ_W'(25000000);
  localparam logic [FREQ_W-1:0]   BAND_HS    = FREQ_W'(52000000);
  localparam logic [FREQ_W-1:0]   MAX_DIV    = FREQ_W'(16);
  localparam logic [PREDIV_W-1:0] MAX_PREDIV = PREDIV_W'(3);
  localparam logic [CNT_W-1:0]    LAST_STEP  = CNT_W'(FREQ_W - 1);

  localparam logic [2:0] SAMP_SLOW = 3'd0;
  localparam logic [2:0] SAMP_SD   = 3'd5;
  localparam logic [2:0] SAMP_HI   = 3'd4;
  localparam logic [2:0] OUTP_SLOW = 3'd0;
  localparam logic [2:0] OUTP_SD   = 3'd0;
  localparam logic [2:0] OUTP_HS   = 3'd3;
  localparam logic [2:0] OUTP_UHS  = 3'd1;

  typedef struct packed {
    logic capture;
    logic ld_div1;
    logic ld_div2;
    logic step;
    logic round;
    logic halve;
  } sdcdp_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic div_gt16;
    logic prediv_max;
  } sdcdp_sts_t;

endpackage

// File: rtl/sdcdp_dp.sv
// Datapath: configuration register, shared restoring divider, halving,
// phase bands and control word packing. Depends on sdcdp_pkg.
module sdcdp_dp
  import sdcdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [FREQ_W-1:0] cfg_pll_periph_freq,
  input  logic [FREQ_W-1:0] in_target_freq,
  input  sdcdp_cmd_t        cmd,
  output sdcdp_sts_t        sts,
  output logic [WORD_W-1:0] clock_word,
  output logic [FREQ_W-1:0] achieved_freq
);

  logic [FREQ_W-1:0]   pll_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [FREQ_W-1:0]   src_r;
  logic                src_pll_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [FREQ_W-1:0]   quo_r;
  logic [FREQ_W-1:0]   dvsr_r;
  logic [FREQ_W-1:0]   div_r;
  logic [PREDIV_W-1:0] prediv_r;

  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              ge;
  logic [FREQ_W:0]   half_sum;
  logic              use_pll;
  logic [2:0]        samp;
  logic [2:0]        outp;
  logic [3:0]        divm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pll_r <= '0;
    end else if (cfg_we) begin
      pll_r <= cfg_pll_periph_freq;
    end
  end

  assign use_pll  = in_target_freq > OSC_FREQ;
  assign trial    = {rem_r, quo_r[FREQ_W-1]};
  assign diff     = trial - {1'b0, dvsr_r};
  assign ge       = trial >= {1'b0, dvsr_r};
  assign half_sum = {1'b0, div_r} + (FREQ_W+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      freq_r    <= in_target_freq;
      src_pll_r <= use_pll;
      src_r     <= use_pll ? pll_r : OSC_FREQ;
      prediv_r  <= '0;
    end
    if (cmd.ld_div1 || cmd.ld_div2) begin
      rem_r  <= '0;
      quo_r  <= src_r;
      dvsr_r <= cmd.ld_div1 ? freq_r : div_r;
    end else if (cmd.step) begin
      rem_r <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      quo_r <= {quo_r[FREQ_W-2:0], ge};
    end
    if (cmd.round) begin
      div_r <= quo_r + FREQ_W'(rem_r != '0);
    end else if (cmd.halve) begin
      div_r    <= half_sum[FREQ_W:1];
      prediv_r <= prediv_r + PREDIV_W'(1);
    end
  end

  assign sts.bad_req    = (freq_r == '0) || (src_r == '0);
  assign sts.div_gt16   = div_r > MAX_DIV;
  assign sts.prediv_max = prediv_r == MAX_PREDIV;

  always_comb begin
    priority if (freq_r <= BAND_SLOW) begin
      samp = SAMP_SLOW;
      outp = OUTP_SLOW;
    end else if (freq_r <= BAND_SD) begin
      samp = SAMP_SD;
      outp = OUTP_SD;
    end else if (freq_r <= BAND_HS) begin
      samp = SAMP_HI;
      outp = OUTP_HS;
    end else begin
      samp = SAMP_HI;
      outp = OUTP_UHS;
    end
  end

  assign divm1 = div_r[3:0] - 4'd1;

  assign clock_word = {1'b1, 6'b0, src_pll_r, 1'b0, samp, 2'b0, prediv_r,
                       5'b0, outp, 4'b0, divm1};
  assign achieved_freq = quo_r;

endmodule

// File: rtl/sdcdp_ctrl.sv
// Controller: sequences capture, two divisions, rounding and halvings,
// and issues the result strobe. Depends on sdcdp_pkg.
module sdcdp_ctrl
  import sdcdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  sdcdp_sts_t sts,
  output sdcdp_cmd_t cmd,
  output logic       busy,
  output logic       out_valid,
  output logic       out_ok
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_ROUND,
    S_HALVE,
    S_DIV2
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_req) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.ld_div1 = 1'b1;
          cnt_nxt     = LAST_STEP;
          state_nxt   = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_HALVE;
      end
      S_HALVE: begin
        priority if (sts.div_gt16 && sts.prediv_max) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.div_gt16) begin
          cmd.halve = 1'b1;
        end else begin
          cmd.ld_div2 = 1'b1;
          cnt_nxt     = LAST_STEP;
          state_nxt   = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without a transaction in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_ok_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_ok_r |-> out_valid_r)
    else $error("ok raised without strobe");

  a_halve_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.halve |-> !sts.prediv_max)
    else $error("halving past prediv limit");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

// File: rtl/sd_clock_divider_planner.sv
// Top level of the SD card clock divider planner: joins sdcdp_ctrl and
// sdcdp_dp. Depends on sdcdp_pkg.
//
//   channel  handshake              payload
//   in       start, busy            in_target_freq[29:0]
//   out      out_valid (strobe)     out_ok, out_clock_word[31:0],
//                                   out_achieved_freq[29:0]
//   cfg      cfg_valid, cfg_ready   cfg_pll_periph_freq[29:0]
//
// A transaction runs two 30-step divider passes with up to three halvings
// between them; a zero request or source, or a need for more than three
// halvings, ends it early with the strobe and out_ok low.
// busy is high from accept until the strobe cycle; start is taken again in
// the strobe cycle. The strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset clears the controller and the PLL register.
module sd_clock_divider_planner
  import sdcdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FREQ_W-1:0] in_target_freq,
  output logic              out_valid,
  output logic              out_ok,
  output logic [WORD_W-1:0] out_clock_word,
  output logic [FREQ_W-1:0] out_achieved_freq,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_pll_periph_freq
);

  sdcdp_cmd_t        cmd;
  sdcdp_sts_t        sts;
  logic              ctrl_start;
  logic [WORD_W-1:0] dp_word;
  logic [FREQ_W-1:0] dp_achieved;

  assign cfg_ready  = 1'b1;
  assign ctrl_start = start && !busy;

  sdcdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl_start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ok    (out_ok)
  );

  sdcdp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_pll_periph_freq (cfg_pll_periph_freq),
    .in_target_freq      (in_target_freq),
    .cmd                 (cmd),
    .sts                 (sts),
    .clock_word          (dp_word),
    .achieved_freq       (dp_achieved)
  );

  assign out_clock_word    = out_ok ? dp_word : '0;
  assign out_achieved_freq = out_ok ? dp_achieved : '0;

endmodule

// File: tb/sv/tb_sd_clock_divider_planner.sv
// Self-checking testbench for sd_clock_divider_planner: drives clock setup requests and
// PLL frequency writes, predicts each clock plan and checks every result strobe.
// Depends on sdcdp_pkg and the sd_clock_divider_planner RTL.
module tb_sd_clock_divider_planner;
  import sdcdp_pkg::*;

  localparam int              RANDOM_REQS = 1750;
  localparam int              CALM_TAIL   = 200;
  localparam int              MAX_SHOWN   = 10;
  localparam bit [FREQ_W-1:0] FREQ_ALL1   = {FREQ_W{1'b1}};
  localparam bit [FREQ_W-1:0] PLL_TOP     = FREQ_W'(768000000);

  typedef enum bit {OP_REQUEST, OP_PLL_WRITE} op_kind_t;

  typedef struct {
    op_kind_t          kind;
    bit [FREQ_W-1:0]   value;
    int                gap;
  } stim_op_t;

  typedef struct packed {
    bit                ok;
    bit [WORD_W-1:0]   word;
    bit [FREQ_W-1:0]   achieved;
  } clk_plan_t;

  logic              clk;
  logic              rst_n;
  logic              start = 1'b0;
  logic              busy;
  logic [FREQ_W-1:0] in_target_freq = '0;
  logic              out_valid;
  logic              out_ok;
  logic [WORD_W-1:0] out_clock_word;
  logic [FREQ_W-1:0] out_achieved_freq;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FREQ_W-1:0] cfg_pll_periph_freq = '0;

  stim_op_t        pending_ops[$];
  clk_plan_t       plans_due[$];
  bit [FREQ_W-1:0] pll_model = '0;
  int              errors = 0;
  int              shown = 0;

  sd_clock_divider_planner dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_target_freq      (in_target_freq),
    .out_valid           (out_valid),
    .out_ok              (out_ok),
    .out_clock_word      (out_clock_word),
    .out_achieved_freq   (out_achieved_freq),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_pll_periph_freq (cfg_pll_periph_freq)
  );

  function automatic clk_plan_t plan_clock(input bit [FREQ_W-1:0] freq,
                                           input bit [FREQ_W-1:0] pll);
    clk_plan_t       plan = '0;
    bit [FREQ_W-1:0] src;
    bit [31:0]       div;
    int unsigned     halvings = 0;
    bit [2:0]        samp;
    bit [2:0]        outp;
    bit              use_pll;
    if (freq == 0) return plan;
    use_pll = freq > OSC_FREQ;
    src = use_pll ? pll : OSC_FREQ;
    if (src == 0) return plan;
    div = 32'(src / freq) + 32'((src % freq) != 0);
    while (div > 32'(MAX_DIV)) begin
      halvings++;
      if (halvings > 32'(MAX_PREDIV)) return plan;
      div = (div + 1) / 2;
    end
    if (freq <= BAND_SLOW) begin
      samp = SAMP_SLOW;
      outp = OUTP_SLOW;
    end else if (freq <= BAND_SD) begin
      samp = SAMP_SD;
      outp = OUTP_SD;
    end else if (freq <= BAND_HS) begin
      samp = SAMP_HI;
      outp = OUTP_HS;
    end else begin
      samp = SAMP_HI;
      outp = OUTP_UHS;
    end
    plan.ok            = 1'b1;
    plan.word[31]      = 1'b1;
    plan.word[24]      = use_pll;
    plan.word[22:20]   = samp;
    plan.word[17:16]   = halvings[1:0];
    plan.word[10:8]    = outp;
    plan.word[3:0]     = 4'(div - 1);
    plan.achieved      = FREQ_W'(src / div);
    return plan;
  endfunction

  task automatic add_req(input bit [FREQ_W-1:0] freq, input int gap);
    pending_ops.push_back('{OP_REQUEST, freq, gap});
  endtask

  task automatic add_pll(input bit [FREQ_W-1:0] pll, input int gap);
    pending_ops.push_back('{OP_PLL_WRITE, pll, gap});
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (start && !busy) begin
        plans_due.push_back(plan_clock(in_target_freq, pll_model));
        void'(pending_ops.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        pll_model = cfg_pll_periph_freq;
        void'(pending_ops.pop_front());
      end
      if (pending_ops.size() == 0) begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending_ops[0].gap != 0) begin
        pending_ops[0].gap = pending_ops[0].gap - 1;
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending_ops[0].kind == OP_REQUEST) begin
        start          <= 1'b1;
        cfg_valid      <= 1'b0;
        in_target_freq <= pending_ops[0].value;
      end else if (plans_due.size() == 0 && !busy && !out_valid && !start) begin
        start               <= 1'b0;
        cfg_valid           <= 1'b1;
        cfg_pll_periph_freq <= pending_ops[0].value;
      end else begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    clk_plan_t want;
    if (rst_n && out_valid) begin
      if (plans_due.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected result: ok=%0d word=%h freq=%0d",
                   out_ok, out_clock_word, out_achieved_freq);
        end
      end else begin
        want = plans_due.pop_front();
        if (out_ok !== want.ok || out_clock_word !== want.word ||
            out_achieved_freq !== want.achieved) begin
          errors++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("mismatch: expected ok=%0d word=%h freq=%0d, got ok=%0d word=%h freq=%0d",
                     want.ok, want.word, want.achieved,
                     out_ok, out_clock_word, out_achieved_freq);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int              issued;
    int              phase_len;
    int              gap;
    int              bits;
    bit              idle_on;
    bit [FREQ_W-1:0] pll;
    bit [FREQ_W-1:0] freq;

    add_pll('0, 0);
    add_req('0, 0);
    add_req(FREQ_W'(1), 0);
    add_req(OSC_FREQ, 2);
    add_req(OSC_FREQ + FREQ_W'(1), 0);
    add_req(FREQ_ALL1, 0);
    add_pll(FREQ_W'(600000000), 0);
    add_req(FREQ_W'(1), 0);
    add_req(BAND_SLOW, 0);
    add_req(BAND_SLOW + FREQ_W'(1), 1);
    add_req(BAND_SD, 0);
    add_req(BAND_SD + FREQ_W'(1), 0);
    add_req(BAND_HS, 0);
    add_req(BAND_HS + FREQ_W'(1), 3);
    add_req(OSC_FREQ + FREQ_W'(1), 0);
    add_req(PLL_TOP, 0);
    add_req(FREQ_ALL1, 0);
    add_req(FREQ_W'(187500), 0);
    add_req(FREQ_W'(187499), 0);
    add_req(FREQ_W'(1500000), 0);
    add_req(FREQ_W'(1411765), 0);
    add_pll(FREQ_ALL1, 0);
    add_req(OSC_FREQ + FREQ_W'(1), 0);
    add_req(FREQ_ALL1, 0);
    add_pll(FREQ_W'(1), 0);
    add_req(OSC_FREQ + FREQ_W'(1), 0);
    add_req(BAND_SLOW, 0);
    add_pll(PLL_TOP, 0);
    add_req(FREQ_W'(48000000), 0);
    add_req(FREQ_W'(6000000), 0);

    issued = 0;
    pll = PLL_TOP;
    while (issued < RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: pll = FREQ_W'($urandom_range(100000000, 768000000));
        6:                pll = '0;
        7:                pll = FREQ_W'($urandom);
        8:                pll = FREQ_ALL1;
        default:          pll = FREQ_W'($urandom_range(1, 60000000));
      endcase
      idle_on = $urandom_range(0, 2) != 0;
      add_pll(pll, (idle_on && issued < RANDOM_REQS - CALM_TAIL) ? $urandom_range(0, 6) : 0);
      phase_len = $urandom_range(60, 180);
      for (int i = 0; i < phase_len && issued < RANDOM_REQS; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: freq = FREQ_W'($urandom_range(1, 24000000));
          3, 4, 5: freq = FREQ_W'($urandom_range(24000001, 768000000));
          6: begin
            bits = $urandom_range(1, FREQ_W);
            freq = FREQ_W'($urandom & ((32'd1 << bits) - 1));
          end
          7: freq = FREQ_W'($urandom);
          8: begin
            case ($urandom_range(0, 9))
              0:       freq = '0;
              1:       freq = FREQ_W'(1);
              2:       freq = BAND_SLOW;
              3:       freq = BAND_SLOW + FREQ_W'(1);
              4:       freq = BAND_SD;
              5:       freq = BAND_SD + FREQ_W'(1);
              6:       freq = BAND_HS;
              7:       freq = BAND_HS + FREQ_W'(1);
              8:       freq = OSC_FREQ;
              default: freq = OSC_FREQ + FREQ_W'(1);
            endcase
          end
          default: begin
            if ($urandom_range(0, 1) != 0 && pll != 0)
              freq = pll / FREQ_W'($urandom_range(1, 140));
            else
              freq = OSC_FREQ / FREQ_W'($urandom_range(1, 140));
            freq = freq + FREQ_W'($urandom_range(0, 2)) - FREQ_W'(1);
          end
        endcase
        gap = 0;
        if (idle_on && issued < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 6);
        add_req(freq, gap);
        issued++;
      end
    end

    while (pending_ops.size() != 0 || plans_due.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0 && plans_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
